// File: rtl/core/sorted_record_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted record table: assertion macros
// Concurrent assertion helpers sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_DEFINES_SVH
`define SORTED_RECORD_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define SRT_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sorted_record_table: check failed");
// The consequent must hold in the cycle after the trigger.
`define SRT_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("sorted_record_table: check failed");
`else
`define SRT_ASSERT(label, cond)
`define SRT_ASSERT_NEXT(label, trig, cons)
`endif

`endif

// File: rtl/core/srt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted record table package
// Transaction payload types, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package srt_pkg;

	// Operation codes of a request transaction.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// Status codes of a response transaction.
	localparam logic [1:0] STATUS_INSERTED  = 2'd0;
	localparam logic [1:0] STATUS_DELETED   = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	localparam int KEY_W  = 16;
	localparam int TEXT_W = 64;
	localparam int OUT_W  = 6;

	typedef struct packed {
		logic              kind;
		logic [KEY_W-1:0]  order_key;
		logic [TEXT_W-1:0] id_key;
		logic [TEXT_W-1:0] name_text;
		logic              gender_flag;
		logic [TEXT_W-1:0] group_text;
	} srt_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OUT_W-1:0] position;
		logic [OUT_W-1:0] occupancy;
	} srt_rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_PLACE,
		ST_REPLY
	} srt_state_t;

endpackage

// File: rtl/core/srt_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying insert and delete transactions.
// ----------------------------------------------------------------------------
interface srt_req_if;
	logic             valid;
	logic             ready;
	srt_pkg::srt_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/srt_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result transaction per request.
// ----------------------------------------------------------------------------
interface srt_rsp_if;
	logic             valid;
	logic             ready;
	srt_pkg::srt_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/srt_rec_mem.sv
// ----------------------------------------------------------------------------
// Record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srt_rec_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 209
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data valid the cycle after the request.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/srt_cmp.sv
// ----------------------------------------------------------------------------
// Shared compare unit
// Tests one stored record against the pending request: key greater for an
// insert, identifier equal for a delete.
// ----------------------------------------------------------------------------
module srt_cmp #(
	parameter int TB = 64
) (
	input  logic                     kind,
	input  logic [srt_pkg::KEY_W-1:0] key_stored,
	input  logic [srt_pkg::KEY_W-1:0] key_item,
	input  logic [TB-1:0]            id_stored,
	input  logic [TB-1:0]            id_item,
	output logic                     hit
);

	// One comparator serves both operations.
	always_comb begin
		if (kind == srt_pkg::KIND_INSERT) begin
			hit = key_stored > key_item;
		end else begin
			hit = id_stored == id_item;
		end
	end

endmodule

// File: rtl/core/sorted_record_table.sv
// ----------------------------------------------------------------------------
// Sorted record table
// Keeps up to TABLE_DEPTH records in ascending key order in one memory;
// inserts and deletes walk the memory one slot at a time.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Transaction
// -------  ---------  ------------------------------------------------------
// req      in         kind, order_key, id_key, name_text, gender_flag,
//                     group_text
// rsp      out        status, position, occupancy
//
// An insert walks down from the last entry to its slot, a delete walks up
// through every entry; the longest operation is a delete that walks a full
// table. Each visited slot costs a memory read and an evaluation with an
// optional write, because the record memory has one registered read port.
// A full insert or an empty delete goes straight to the reply.
// Reset clears the entry count but not the records; records are valid below that count.
// The request side is ready only when the sequencer is idle; a result that
// is not taken holds in the output register and stalls the next reply.
// ----------------------------------------------------------------------------
`include "sorted_record_table_defines.svh"

module sorted_record_table #(
	parameter int TABLE_DEPTH = 32,
	parameter int TEXT_CHARS  = 8
) (
	input logic      clk,
	input logic      arst_n,
	srt_req_if.sink  req,
	srt_rsp_if.source rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TB = 8 * TEXT_CHARS;
	localparam int KW = srt_pkg::KEY_W;
	localparam int RW = KW + 3 * TB + 1;

	// Record layout: {key, identifier, name, gender, group}.
	localparam int IDT_LSB = 2 * TB + 1;
	localparam int KEY_LSB = 3 * TB + 1;

	srt_pkg::srt_state_t state_q, state_d;

	logic              kind_q;
	logic [KW-1:0]     key_q;
	logic [TB-1:0]     id_q;
	logic [TB-1:0]     name_q;
	logic              gen_q;
	logic [TB-1:0]     grp_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     count_q;
	logic              found_q;
	logic [1:0]        status_q;
	logic              rsp_valid_q;
	srt_pkg::srt_rsp_t rsp_data_q;

	logic          mem_we;
	logic [CW-1:0] mem_waddr;
	logic [RW-1:0] mem_wdata;
	logic          mem_re;
	logic [RW-1:0] mem_rdata;
	logic          hit;
	logic          req_fire;
	logic          rsp_fire;
	logic          reply_load;
	logic          is_full;
	logic          is_empty;
	logic          last_slot;
	logic [CW+5:0] pos_ext;
	logic [CW+5:0] count_ext;

	assign req_fire   = req.valid && req.ready;
	assign rsp_fire   = rsp_valid_q && rsp.ready;
	assign reply_load = (state_q == srt_pkg::ST_REPLY) && (!rsp_valid_q || rsp.ready);
	assign is_full    = count_q == CW'(TABLE_DEPTH);
	assign is_empty   = count_q == '0;
	assign last_slot  = (idx_q + 1'b1) == count_q;
	assign pos_ext    = {6'd0, pos_q};
	assign count_ext  = {6'd0, count_q};

	// Record memory.
	srt_rec_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (RW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr[AW-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	// Compare unit shared by the insert and delete walks.
	srt_cmp #(
		.TB (TB)
	) u_cmp (
		.kind       (kind_q),
		.key_stored (mem_rdata[KEY_LSB +: KW]),
		.key_item   (key_q),
		.id_stored  (mem_rdata[IDT_LSB +: TB]),
		.id_item    (id_q),
		.hit        (hit)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			srt_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.data.kind == srt_pkg::KIND_INSERT) begin
						if (is_full) begin
							state_d = srt_pkg::ST_REPLY;
						end else if (is_empty) begin
							state_d = srt_pkg::ST_PLACE;
						end else begin
							state_d = srt_pkg::ST_READ;
						end
					end else begin
						state_d = is_empty ? srt_pkg::ST_REPLY : srt_pkg::ST_READ;
					end
				end
			end
			srt_pkg::ST_READ: state_d = srt_pkg::ST_EVAL;
			srt_pkg::ST_EVAL: begin
				if (kind_q == srt_pkg::KIND_INSERT) begin
					state_d = (hit && idx_q != '0) ? srt_pkg::ST_READ : srt_pkg::ST_PLACE;
				end else begin
					state_d = last_slot ? srt_pkg::ST_REPLY : srt_pkg::ST_READ;
				end
			end
			srt_pkg::ST_PLACE: state_d = srt_pkg::ST_REPLY;
			srt_pkg::ST_REPLY: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = srt_pkg::ST_IDLE;
				end
			end
			default: state_d = srt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and memory control.
	always_comb begin
		req.ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		case (state_q)
			srt_pkg::ST_IDLE: req.ready = 1'b1;
			srt_pkg::ST_READ: mem_re = 1'b1;
			srt_pkg::ST_EVAL: begin
				// Insert moves a greater record up; delete moves records after
				// the match down.
				if (kind_q == srt_pkg::KIND_INSERT) begin
					mem_we    = hit;
					mem_waddr = idx_q + 1'b1;
				end else begin
					mem_we    = found_q;
					mem_waddr = idx_q - 1'b1;
				end
			end
			srt_pkg::ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = {key_q, id_q, name_q, gen_q, grp_q};
			end
			srt_pkg::ST_REPLY: ;
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req.data.kind;
			key_q  <= req.data.order_key;
			id_q   <= req.data.id_key[TB-1:0];
			name_q <= req.data.name_text[TB-1:0];
			gen_q  <= req.data.gender_flag;
			grp_q  <= req.data.group_text[TB-1:0];
		end
	end

	// Walk index, position, entry count and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			pos_q    <= '0;
			count_q  <= '0;
			found_q  <= 1'b0;
			status_q <= srt_pkg::STATUS_INSERTED;
		end else begin
			case (state_q)
				srt_pkg::ST_IDLE: begin
					if (req_fire) begin
						found_q <= 1'b0;
						pos_q   <= '0;
						if (req.data.kind == srt_pkg::KIND_INSERT) begin
							idx_q    <= count_q - 1'b1;
							status_q <= srt_pkg::STATUS_FULL;
						end else begin
							idx_q    <= '0;
							status_q <= srt_pkg::STATUS_NOT_FOUND;
						end
					end
				end
				srt_pkg::ST_EVAL: begin
					if (kind_q == srt_pkg::KIND_INSERT) begin
						// Walk down while stored keys are greater.
						if (hit) begin
							if (idx_q == '0) begin
								pos_q <= '0;
							end else begin
								idx_q <= idx_q - 1'b1;
							end
						end else begin
							pos_q <= idx_q + 1'b1;
						end
					end else begin
						// Walk up; the first matching identifier is removed.
						if (!found_q && hit) begin
							found_q <= 1'b1;
							pos_q   <= idx_q;
						end
						if (last_slot) begin
							if (found_q || hit) begin
								count_q  <= count_q - 1'b1;
								status_q <= srt_pkg::STATUS_DELETED;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				srt_pkg::ST_PLACE: begin
					count_q  <= count_q + 1'b1;
					status_q <= srt_pkg::STATUS_INSERTED;
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (reply_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (reply_load) begin
			rsp_data_q.status    <= status_q;
			rsp_data_q.position  <= pos_ext[5:0];
			rsp_data_q.occupancy <= count_ext[5:0];
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Checks.
	`SRT_ASSERT(a_count_bound, count_q <= CW'(TABLE_DEPTH))
	`SRT_ASSERT(a_no_write_idle, !(state_q == srt_pkg::ST_IDLE && mem_we))
	`SRT_ASSERT_NEXT(a_place_grows, state_q == srt_pkg::ST_PLACE, count_q == $past(count_q) + 1'b1)
	`SRT_ASSERT_NEXT(a_accept_busy, req_fire, state_q != srt_pkg::ST_IDLE)

endmodule
